### src/tlw_pkg.sv
// Shared types, constants and register codes of the text line wrap block.
package tlw_pkg;

  localparam int unsigned CH_W = 8;
  localparam int unsigned IDX_W = 64;
  localparam int unsigned COL_W = 16;
  localparam int unsigned CNT_W = 10;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned TAB_WIDTH = 4;

  localparam logic [CH_W-1:0] CH_NUL = 8'd0;
  localparam logic [CH_W-1:0] CH_TAB = 8'd9;
  localparam logic [CH_W-1:0] CH_NL = 8'd10;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 2'd2;

  localparam logic [CNT_W-1:0] LINE_WIDTH_RST = 10'd80;
  localparam logic [CNT_W-1:0] LINE_LIMIT_RST = 10'd0;
  localparam logic [CNT_W-1:0] SCREEN_ROWS_RST = 10'd25;

  typedef struct packed {
    logic [CNT_W-1:0] line_width;
    logic [CNT_W-1:0] line_limit;
    logic [CNT_W-1:0] screen_rows;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [IDX_W-1:0] char_index;
    logic             in_window;
    logic             first;
    logic             end_of_run;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] glyph_count;
    logic [COL_W-1:0] logical_column;
    logic             newline_pending;
    logic             line_full;
    logic [CNT_W-1:0] window_lines;
    logic             halted;
  } state_t;

  typedef struct packed {
    logic             line_break;
    logic             tab_split;
    logic [IDX_W-1:0] line_start_index;
    logic [COL_W-1:0] start_logical_column;
    logic [CNT_W-1:0] glyph_column;
    logic [CNT_W-1:0] lines_written;
    logic             stopped;
    logic             line_done;
    logic             run_done;
  } result_t;

endpackage

### src/tlw_if.sv
// Channel interfaces of the text line wrap block: characters, results, configuration.
interface tlw_in_if;
  logic                        valid;
  logic                        ready;
  logic [tlw_pkg::CH_W-1:0]    ch;
  logic [tlw_pkg::IDX_W-1:0]   char_index;
  logic                        in_window;
  logic                        first;
  logic                        end_of_run;

  modport source (output valid, ch, char_index, in_window, first, end_of_run, input ready);
  modport sink (input valid, ch, char_index, in_window, first, end_of_run, output ready);
endinterface

interface tlw_out_if;
  logic                        valid;
  logic                        ready;
  logic                        line_break;
  logic                        tab_split;
  logic [tlw_pkg::IDX_W-1:0]   line_start_index;
  logic [tlw_pkg::COL_W-1:0]   start_logical_column;
  logic [tlw_pkg::CNT_W-1:0]   glyph_column;
  logic [tlw_pkg::CNT_W-1:0]   lines_written;
  logic                        stopped;
  logic                        line_done;
  logic                        run_done;

  modport source (output valid, line_break, tab_split, line_start_index,
                  start_logical_column, glyph_column, lines_written, stopped,
                  line_done, run_done, input ready);
  modport sink (input valid, line_break, tab_split, line_start_index,
                start_logical_column, glyph_column, lines_written, stopped,
                line_done, run_done, output ready);
endinterface

interface tlw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tlw_pkg::CFG_IDX_W-1:0] index;
  logic [tlw_pkg::CNT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/tlw_cfg_regs.sv
// Configuration register file: line width, line limit and screen rows.
module tlw_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  tlw_cfg_if.sink         cfg_i,
  output tlw_pkg::cfg_t   cfg_o
);

  tlw_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        tlw_pkg::CFG_LINE_WIDTH:  cfg_d.line_width = cfg_i.data;
        tlw_pkg::CFG_LINE_LIMIT:  cfg_d.line_limit = cfg_i.data;
        tlw_pkg::CFG_SCREEN_ROWS: cfg_d.screen_rows = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width <= tlw_pkg::LINE_WIDTH_RST;
      cfg_q.line_limit <= tlw_pkg::LINE_LIMIT_RST;
      cfg_q.screen_rows <= tlw_pkg::SCREEN_ROWS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### src/tlw_step.sv
// Per-character layout step: next wrap state and the result of one character.
module tlw_step #(
  parameter int unsigned TabWidth = tlw_pkg::TAB_WIDTH,
  localparam int unsigned PhW = (TabWidth > 2) ? $clog2(TabWidth) : 1
) (
  input  tlw_pkg::cfg_t    cfg_i,
  input  tlw_pkg::item_t   item_i,
  input  tlw_pkg::state_t  state_i,
  input  logic [PhW-1:0]   phase_i,
  output tlw_pkg::state_t  state_o,
  output logic [PhW-1:0]   phase_o,
  output tlw_pkg::result_t result_o
);

  localparam int unsigned AddW = $clog2(TabWidth + 1);
  localparam int unsigned ColRange = 1 << tlw_pkg::COL_W;
  localparam int unsigned WrapPhase = (TabWidth - (ColRange % TabWidth)) % TabWidth;
  localparam logic [PhW-1:0] PhaseLast = PhW'(TabWidth - 1);
  localparam logic [AddW-1:0] TabW = AddW'(TabWidth);

  tlw_pkg::state_t          st;
  tlw_pkg::result_t         res;
  logic [PhW-1:0]           ph;
  logic                     skip;
  logic [AddW-1:0]          add;
  logic [tlw_pkg::CNT_W:0]  sum;
  logic [tlw_pkg::CNT_W-1:0] extra;
  logic [tlw_pkg::CNT_W-1:0] rem;
  logic [tlw_pkg::COL_W:0]  col_sum;

  always_comb begin
    st = state_i;
    ph = phase_i;
    skip = 1'b0;
    res = '0;
    add = TabW - AddW'(phase_i);
    sum = '0;
    extra = '0;
    rem = '0;
    col_sum = '0;

    if (item_i.first) begin
      st.glyph_count = '0;
      st.logical_column = '0;
      st.newline_pending = 1'b0;
      st.line_full = 1'b0;
      st.halted = 1'b0;
      st.window_lines = tlw_pkg::CNT_W'(item_i.in_window);
      ph = '0;
      res.line_break = 1'b1;
      res.line_start_index = item_i.char_index;
    end else if (state_i.halted) begin
      skip = 1'b1;
    end else if (state_i.newline_pending ||
                 (state_i.line_full && item_i.ch != tlw_pkg::CH_NL)) begin
      if (cfg_i.line_limit != '0 && state_i.window_lines >= cfg_i.line_limit) begin
        st.halted = 1'b1;
        skip = 1'b1;
      end else begin
        res.line_break = 1'b1;
        res.line_start_index = item_i.char_index;
        res.start_logical_column = state_i.logical_column;
        st.glyph_count = '0;
        if (item_i.in_window && state_i.window_lines != tlw_pkg::CNT_MAX) begin
          st.window_lines = state_i.window_lines + 1'b1;
        end
        st.newline_pending = 1'b0;
        st.line_full = 1'b0;
      end
    end else if (state_i.line_full) begin
      st.line_full = 1'b0;
    end

    add = TabW - AddW'(ph);
    sum = (tlw_pkg::CNT_W + 1)'(st.glyph_count) + (tlw_pkg::CNT_W + 1)'(add);
    extra = (st.glyph_count < cfg_i.line_width) ? (cfg_i.line_width - st.glyph_count) : '0;
    rem = tlw_pkg::CNT_W'(add) - extra;
    col_sum = (tlw_pkg::COL_W + 1)'(st.logical_column) + (tlw_pkg::COL_W + 1)'(add);

    if (!skip) begin
      priority if (item_i.ch == tlw_pkg::CH_NUL) begin
      end else if (item_i.ch == tlw_pkg::CH_NL) begin
        st.newline_pending = 1'b1;
        st.line_full = 1'b0;
        st.logical_column = '0;
        ph = '0;
      end else if (item_i.ch == tlw_pkg::CH_TAB) begin
        if (sum <= (tlw_pkg::CNT_W + 1)'(cfg_i.line_width)) begin
          st.glyph_count = tlw_pkg::CNT_W'(sum);
          if (tlw_pkg::CNT_W'(sum) == cfg_i.line_width) begin
            st.line_full = 1'b1;
          end
          st.logical_column = col_sum[tlw_pkg::COL_W-1:0];
          ph = col_sum[tlw_pkg::COL_W] ? PhW'(WrapPhase) : '0;
        end else if (cfg_i.line_limit != '0 && st.window_lines >= cfg_i.line_limit) begin
          st.halted = 1'b1;
        end else begin
          if (rem >= cfg_i.line_width) begin
            st.glyph_count = cfg_i.line_width;
            st.line_full = 1'b1;
          end else begin
            st.glyph_count = rem;
          end
          res.line_break = 1'b1;
          res.tab_split = 1'b1;
          res.line_start_index = item_i.char_index;
          res.start_logical_column = st.logical_column + tlw_pkg::COL_W'(extra);
          if (item_i.in_window && st.window_lines != tlw_pkg::CNT_MAX) begin
            st.window_lines = st.window_lines + 1'b1;
          end
          st.logical_column = col_sum[tlw_pkg::COL_W-1:0];
          ph = col_sum[tlw_pkg::COL_W] ? PhW'(WrapPhase) : '0;
        end
      end else begin
        if (st.glyph_count != tlw_pkg::CNT_MAX) begin
          st.glyph_count = st.glyph_count + 1'b1;
        end
        ph = (st.logical_column == '1 || ph == PhaseLast) ? '0 : ph + 1'b1;
        st.logical_column = st.logical_column + 1'b1;
        if (st.glyph_count >= cfg_i.line_width) begin
          st.line_full = 1'b1;
        end
      end
    end

    res.glyph_column = st.glyph_count;
    res.lines_written = (st.window_lines < cfg_i.screen_rows) ? st.window_lines
                                                              : cfg_i.screen_rows;
    res.stopped = st.halted;
    res.line_done = st.newline_pending || st.line_full;
    res.run_done = item_i.end_of_run;
  end

  assign state_o = st;
  assign phase_o = ph;
  assign result_o = res;

endmodule

### src/text_line_wrap_tab_expand.sv
// Top level of the soft line wrap block with tab expansion.
//
// Characters enter on in_i, one per transaction, and every character yields
// exactly one result transaction on out_o, in order. The configuration
// channel cfg_i writes line_width (index 0), line_limit (index 1) and
// screen_rows (index 2); it is always ready. The user must write it only
// while the block holds no character in flight; the block does not enforce it.
// A character passes an input register, the layout step and a result
// register, in that order. The wrap state is read and written in the
// layout step, so characters follow one another at one per cycle while
// the receiver takes the results, and both registers move forward together.
// When the receiver stalls, the result register holds its result and the
// input register takes one more character; in_i.ready then falls until the
// result is taken.
// Reset clears both registers, the wrap state and the configuration to
// line_width 80, line_limit 0 and screen_rows 25; no clearing pass follows.
module text_line_wrap_tab_expand #(
  parameter int unsigned TabWidth = tlw_pkg::TAB_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tlw_in_if.sink    in_i,
  tlw_out_if.source out_o,
  tlw_cfg_if.sink   cfg_i
);

  localparam int unsigned PhW = (TabWidth > 2) ? $clog2(TabWidth) : 1;

  tlw_pkg::cfg_t    cfg;
  tlw_pkg::item_t   item_q;
  logic             item_valid_q;
  tlw_pkg::state_t  state_q, state_d;
  logic [PhW-1:0]   phase_q, phase_d;
  tlw_pkg::result_t res_q, res_d;
  logic             res_valid_q;
  logic             advance;

  tlw_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  tlw_step #(
    .TabWidth (TabWidth)
  ) u_step (
    .cfg_i    (cfg),
    .item_i   (item_q),
    .state_i  (state_q),
    .phase_i  (phase_q),
    .state_o  (state_d),
    .phase_o  (phase_d),
    .result_o (res_d)
  );

  assign advance = item_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.ch <= in_i.ch;
      item_q.char_index <= in_i.char_index;
      item_q.in_window <= in_i.in_window;
      item_q.first <= in_i.first;
      item_q.end_of_run <= in_i.end_of_run;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      phase_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
        phase_q <= phase_d;
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = res_valid_q;
  assign out_o.line_break = res_q.line_break;
  assign out_o.tab_split = res_q.tab_split;
  assign out_o.line_start_index = res_q.line_start_index;
  assign out_o.start_logical_column = res_q.start_logical_column;
  assign out_o.glyph_column = res_q.glyph_column;
  assign out_o.lines_written = res_q.lines_written;
  assign out_o.stopped = res_q.stopped;
  assign out_o.line_done = res_q.line_done;
  assign out_o.run_done = res_q.run_done;

endmodule

### src/tlw_checker.sv
// Port-level checks of the text line wrap block and their binding to the top level.
module tlw_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        line_break_i,
  input logic                        tab_split_i,
  input logic [tlw_pkg::IDX_W-1:0]   line_start_index_i,
  input logic [tlw_pkg::COL_W-1:0]   start_logical_column_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result transaction dropped while stalled");

  a_split_breaks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && tab_split_i |-> line_break_i)
    else $error("tab split reported without a line break");

  a_no_break_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !line_break_i |->
      line_start_index_i == '0 && start_logical_column_i == '0)
    else $error("line start reported without a line break");

  a_reset_idle: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

endmodule

bind text_line_wrap_tab_expand tlw_checker u_tlw_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .out_valid_i            (out_o.valid),
  .out_ready_i            (out_o.ready),
  .line_break_i           (out_o.line_break),
  .tab_split_i            (out_o.tab_split),
  .line_start_index_i     (out_o.line_start_index),
  .start_logical_column_i (out_o.start_logical_column)
);

### bench/text_line_wrap_tab_expand_tb.sv
// Self-checking testbench of the soft line wrap block with tab expansion.
module text_line_wrap_tab_expand_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 40000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tlw_in_if  chars_if ();
  tlw_out_if layout_if ();
  tlw_cfg_if cfg_if ();

  text_line_wrap_tab_expand dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (chars_if),
    .out_o  (layout_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mirror of the wrap configuration and state.
  logic [tlw_pkg::CNT_W-1:0] line_width = tlw_pkg::LINE_WIDTH_RST;
  logic [tlw_pkg::CNT_W-1:0] line_limit = tlw_pkg::LINE_LIMIT_RST;
  logic [tlw_pkg::CNT_W-1:0] screen_rows = tlw_pkg::SCREEN_ROWS_RST;
  logic [tlw_pkg::CNT_W-1:0] glyph_count = '0;
  logic [tlw_pkg::COL_W-1:0] logical_column = '0;
  logic             nl_pending = 1'b0;
  logic             line_full = 1'b0;
  logic [tlw_pkg::CNT_W-1:0] window_lines = '0;
  logic             halted = 1'b0;

  tlw_pkg::item_t   text_chars[$];
  tlw_pkg::result_t pending_layouts[$];
  tlw_pkg::item_t   next_char;
  tlw_pkg::item_t   seen_char;
  tlw_pkg::result_t want_layout;
  logic        char_taken = 1'b0;
  bit          calm = 1'b0;
  int unsigned wrap_errors = 0;
  int unsigned layouts_seen = 0;
  int unsigned cycle_count = 0;
  logic [tlw_pkg::IDX_W-1:0] next_index = '0;

  function automatic bit limit_hit();
    return line_limit != '0 && window_lines >= line_limit;
  endfunction

  function automatic void count_line(logic win);
    if (win && window_lines < tlw_pkg::CNT_MAX) window_lines = window_lines + 1'b1;
  endfunction

  function automatic tlw_pkg::result_t wrap_char(tlw_pkg::item_t c);
    tlw_pkg::result_t r;
    bit          skip;
    int unsigned add;
    int unsigned extra;
    int unsigned rem;
    r = '0;
    skip = 1'b0;
    if (c.first) begin
      glyph_count = '0;
      logical_column = '0;
      nl_pending = 1'b0;
      line_full = 1'b0;
      halted = 1'b0;
      window_lines = tlw_pkg::CNT_W'(c.in_window);
      r.line_break = 1'b1;
      r.line_start_index = c.char_index;
    end else if (halted) begin
      skip = 1'b1;
    end else if (nl_pending || (line_full && c.ch != tlw_pkg::CH_NL)) begin
      if (limit_hit()) begin
        halted = 1'b1;
        skip = 1'b1;
      end else begin
        r.line_break = 1'b1;
        r.line_start_index = c.char_index;
        r.start_logical_column = logical_column;
        glyph_count = '0;
        count_line(c.in_window);
        nl_pending = 1'b0;
        line_full = 1'b0;
      end
    end else if (line_full) begin
      line_full = 1'b0;
    end

    if (!skip) begin
      if (c.ch == tlw_pkg::CH_NL) begin
        nl_pending = 1'b1;
        line_full = 1'b0;
        logical_column = '0;
      end else if (c.ch == tlw_pkg::CH_TAB) begin
        add = tlw_pkg::TAB_WIDTH - (logical_column % tlw_pkg::TAB_WIDTH);
        if (int'(glyph_count) + add <= int'(line_width)) begin
          glyph_count = glyph_count + tlw_pkg::CNT_W'(add);
          if (glyph_count == line_width) line_full = 1'b1;
          logical_column = logical_column + tlw_pkg::COL_W'(add);
        end else if (limit_hit()) begin
          halted = 1'b1;
        end else begin
          extra = (glyph_count < line_width) ? int'(line_width) - int'(glyph_count) : 0;
          rem = add - extra;
          if (rem >= line_width) begin
            glyph_count = line_width;
            line_full = 1'b1;
          end else begin
            glyph_count = tlw_pkg::CNT_W'(rem);
          end
          r.line_break = 1'b1;
          r.tab_split = 1'b1;
          r.line_start_index = c.char_index;
          r.start_logical_column = logical_column + tlw_pkg::COL_W'(extra);
          count_line(c.in_window);
          logical_column = logical_column + tlw_pkg::COL_W'(add);
        end
      end else if (c.ch != tlw_pkg::CH_NUL) begin
        if (glyph_count < tlw_pkg::CNT_MAX) glyph_count = glyph_count + 1'b1;
        logical_column = logical_column + 1'b1;
        if (glyph_count >= line_width) line_full = 1'b1;
      end
    end

    r.glyph_column = glyph_count;
    r.lines_written = (window_lines < screen_rows) ? window_lines : screen_rows;
    r.stopped = halted;
    r.line_done = nl_pending || line_full;
    r.run_done = c.end_of_run;
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    $display("[%0t] layout %0d: %s", $time, layouts_seen, what);
    wrap_errors++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 29);
  endfunction

  // Sender side: a new character is offered once the previous one has gone.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!chars_if.valid || char_taken) begin
        if (text_chars.size() > 0 && !take_break()) begin
          next_char = text_chars.pop_front();
          chars_if.valid <= 1'b1;
          chars_if.ch <= next_char.ch;
          chars_if.char_index <= next_char.char_index;
          chars_if.in_window <= next_char.in_window;
          chars_if.first <= next_char.first;
          chars_if.end_of_run <= next_char.end_of_run;
        end else begin
          chars_if.valid <= 1'b0;
        end
      end
      layout_if.ready <= !take_break();
    end
  end

  // Both channels are observed at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      char_taken = chars_if.valid && chars_if.ready;
      if (char_taken) begin
        seen_char.ch = chars_if.ch;
        seen_char.char_index = chars_if.char_index;
        seen_char.in_window = chars_if.in_window;
        seen_char.first = chars_if.first;
        seen_char.end_of_run = chars_if.end_of_run;
        pending_layouts.push_back(wrap_char(seen_char));
      end
      if (layout_if.valid && layout_if.ready) begin
        if (pending_layouts.size() == 0) begin
          flag_mismatch("result transaction with nothing expected");
        end else begin
          want_layout = pending_layouts.pop_front();
          check_field("line_break", layout_if.line_break, want_layout.line_break);
          check_field("tab_split", layout_if.tab_split, want_layout.tab_split);
          check_field("line_start_index", layout_if.line_start_index,
                      want_layout.line_start_index);
          check_field("start_logical_column", layout_if.start_logical_column,
                      want_layout.start_logical_column);
          check_field("glyph_column", layout_if.glyph_column, want_layout.glyph_column);
          check_field("lines_written", layout_if.lines_written, want_layout.lines_written);
          check_field("stopped", layout_if.stopped, want_layout.stopped);
          check_field("line_done", layout_if.line_done, want_layout.line_done);
          check_field("run_done", layout_if.run_done, want_layout.run_done);
        end
        layouts_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_char(logic [tlw_pkg::CH_W-1:0] ch, logic [tlw_pkg::IDX_W-1:0] idx,
                           logic win, logic first, logic eor);
    tlw_pkg::item_t c;
    c.ch = ch;
    c.char_index = idx;
    c.in_window = win;
    c.first = first;
    c.end_of_run = eor;
    text_chars.push_back(c);
  endtask

  task automatic push_next(logic [tlw_pkg::CH_W-1:0] ch, logic win, logic first);
    push_char(ch, next_index, win, first, 1'b0);
    next_index = next_index + 1'b1;
  endtask

  function automatic logic [tlw_pkg::CH_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 14) return tlw_pkg::CH_NL;
    if (r < 28) return tlw_pkg::CH_TAB;
    if (r < 33) return tlw_pkg::CH_NUL;
    return tlw_pkg::CH_W'($urandom_range(255));
  endfunction

  // A run opens with first, may have a window start somewhere inside it and ends
  // with end_of_run. Some items are plain noise.
  task automatic queue_random(int unsigned total);
    int unsigned made;
    int unsigned len;
    int unsigned wstart;
    logic [tlw_pkg::IDX_W-1:0] base;
    made = 0;
    while (made < total) begin
      if ($urandom_range(9) == 0) begin
        push_char(tlw_pkg::CH_W'($urandom_range(255)), {$urandom, $urandom}, 1'($urandom),
                  $urandom_range(4) == 0, 1'($urandom));
        made++;
      end else begin
        len = $urandom_range(5, 120);
        if (len > total - made) len = total - made;
        wstart = $urandom_range(len);
        base = {$urandom, $urandom};
        for (int unsigned k = 0; k < len; k++)
          push_char(pick_char(), base + k, k >= wstart, k == 0, k == len - 1);
        made += len;
      end
    end
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (!(text_chars.size() == 0 && pending_layouts.size() == 0 && !chars_if.valid));
  endtask

  task automatic write_reg(logic [tlw_pkg::CFG_IDX_W-1:0] idx,
                           logic [tlw_pkg::CNT_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      tlw_pkg::CFG_LINE_WIDTH:  line_width = val;
      tlw_pkg::CFG_LINE_LIMIT:  line_limit = val;
      tlw_pkg::CFG_SCREEN_ROWS: screen_rows = val;
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned width, int unsigned limit, int unsigned rows);
    settle();
    write_reg(tlw_pkg::CFG_LINE_WIDTH, tlw_pkg::CNT_W'(width));
    write_reg(tlw_pkg::CFG_LINE_LIMIT, tlw_pkg::CNT_W'(limit));
    write_reg(tlw_pkg::CFG_SCREEN_ROWS, tlw_pkg::CNT_W'(rows));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    chars_if.valid = 1'b0;
    chars_if.ch = '0;
    chars_if.char_index = '0;
    chars_if.in_window = 1'b0;
    chars_if.first = 1'b0;
    chars_if.end_of_run = 1'b0;
    layout_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. A character without first right after reset continues
    // the reset state; then eight glyphs fill part of a wide line.
    push_char(8'h41, '0, 1'b0, 1'b0, 1'b0);
    push_char(8'hFF, '0, 1'b1, 1'b1, 1'b0);
    push_char(tlw_pkg::CH_NUL, 64'd1, 1'b1, 1'b0, 1'b0);
    next_index = 64'd2;
    for (int k = 0; k < 7; k++) push_next(8'h62 + tlw_pkg::CH_W'(k), 1'b1, 1'b0);

    // The width shrinks below the glyphs already used, so the next tab splits
    // with nothing left on the old line and a remainder that fills the new one.
    set_config(4, 0, 25);
    push_next(tlw_pkg::CH_TAB, 1'b1, 1'b0);
    push_next(8'h78, 1'b1, 1'b0);
    push_next(tlw_pkg::CH_NL, 1'b1, 1'b0);
    push_next(tlw_pkg::CH_NL, 1'b0, 1'b0);
    push_next(tlw_pkg::CH_TAB, 1'b1, 1'b0);
    push_next(tlw_pkg::CH_NL, 1'b1, 1'b0);
    push_char(8'h79, '1, 1'b0, 1'b0, 1'b1);

    // A tab that overflows the line with the limit reached stops the block.
    set_config(5, 1, 1);
    next_index = 64'd100;
    push_next(8'h61, 1'b1, 1'b1);
    for (int k = 0; k < 3; k++) push_next(8'h62 + tlw_pkg::CH_W'(k), 1'b1, 1'b0);
    push_next(tlw_pkg::CH_TAB, 1'b1, 1'b0);
    push_next(8'h65, 1'b1, 1'b0);

    set_config(80, 0, 25);
    queue_random(110);
    set_config(4, 0, 1023);
    queue_random(90);
    set_config(7, 3, 2);
    queue_random(90);
    repeat (3) begin
      set_config($urandom_range(4, 40), $urandom_range(0, 6), $urandom_range(1, 30));
      queue_random(90);
    end

    // One long stretch without idling: a long line at the widest setting,
    // a series of newlines and a series of tabs.
    set_config(1023, 0, 1023);
    calm = 1'b1;
    next_index = {$urandom, $urandom};
    push_next(8'h78, 1'b1, 1'b1);
    for (int k = 0; k < 60; k++)
      push_next(tlw_pkg::CH_W'($urandom_range(11, 255)), 1'b1, 1'b0);
    for (int k = 0; k < 20; k++) push_next(tlw_pkg::CH_NL, 1'b1, 1'b0);
    for (int k = 0; k < 30; k++) push_next(tlw_pkg::CH_TAB, 1'($urandom), 1'b0);
    for (int k = 0; k < 5; k++) push_next(8'h7A, 1'b1, 1'b0);

    // A small limit that the line count already meets stops the next line.
    set_config(1023, 2, 1023);
    for (int k = 0; k < 3; k++) push_next(8'h61, 1'b1, 1'b0);
    push_next(tlw_pkg::CH_NL, 1'b1, 1'b0);
    push_next(8'h62, 1'b1, 1'b0);
    push_next(8'h63, 1'b1, 1'b0);
    calm = 1'b0;
    queue_random(50);

    settle();
    repeat (8) @(posedge clk_i);
    if (wrap_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
